### src/ses2d_pkg.sv
// Shared types, constants and fixed-point helpers for the 2D exponential stress pipeline.
`timescale 1ns / 1ps

package ses2d_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int EXP_FRAC  = 30;
    localparam int TERMS     = 12;
    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam t_word EXP_LIM  = t_word'(48 <<< FRAC_W);

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE     = 3'd0,
        REG_E11_SQ    = 3'd1,
        REG_E22_SQ    = 3'd2,
        REG_E11_E22   = 3'd3,
        REG_E12_SQ    = 3'd4,
        REG_E12_E11   = 3'd5,
        REG_E12_E22   = 3'd6
    } t_reg_idx;

    // value plus saturation flag
    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_sv;

    typedef struct packed {
        t_word a;
        t_word c11;
        t_word c22;
        t_word c1122;
        t_word c12;
        t_word c1211;
        t_word c1222;
    } t_coef;

    typedef struct packed {
        t_word e11;
        t_word e22;
        t_word e12;
        logic  ovf;
    } t_strain;

    typedef struct packed {
        t_word lam;
        t_word d11;
        t_word d12;
        t_word d22;
        logic  ovf;
    } t_quad;

    // product rounded to nearest, ties away from zero, then saturated
    function automatic t_sv f_smul(input t_word a, input t_word b);
        logic             neg;
        logic [WORD_W-1:0] ma;
        logic [WORD_W-1:0] mb;
        logic [2*WORD_W-1:0] p;
        logic [2*WORD_W-1:0] q;
        t_sv              r;
        neg = a[WORD_W-1] ^ b[WORD_W-1];
        ma  = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
        mb  = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
        p   = (2*WORD_W)'(ma) * (2*WORD_W)'(mb);
        q   = (p + ((2*WORD_W)'(1) << (FRAC_W - 1))) >> FRAC_W;
        r.ovf = 1'b0;
        if (!neg && q > (2*WORD_W)'(WORD_MAX)) begin
            r.ovf = 1'b1;
            r.val = WORD_MAX;
        end else if (neg && q > ((2*WORD_W)'(1) << (WORD_W - 1))) begin
            r.ovf = 1'b1;
            r.val = WORD_MIN;
        end else begin
            r.val = neg ? t_word'(WORD_W'(0) - q[WORD_W-1:0]) : t_word'(q[WORD_W-1:0]);
        end
        return r;
    endfunction

    function automatic t_sv f_sadd(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        t_sv                    r;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        r.ovf = s[WORD_W] ^ s[WORD_W-1];
        if (r.ovf) begin
            r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            r.val = s[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_word f_asr1(input t_word v);
        return v >>> 1;
    endfunction

endpackage

### src/ses2d_strain.sv
// Green-Lagrange strain from the displacement gradient, three stages.
`timescale 1ns / 1ps

module ses2d_strain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ses2d_pkg::t_word   i_g11,
    input  ses2d_pkg::t_word   i_g12,
    input  ses2d_pkg::t_word   i_g21,
    input  ses2d_pkg::t_word   i_g22,
    output logic               o_valid,
    output ses2d_pkg::t_strain o_strain
);
    import ses2d_pkg::*;

    logic    r_v1, r_v2, r_v3;
    t_sv     r_p11, r_p21, r_p12, r_p22, r_pa, r_pb;
    t_word   r_g11, r_g12, r_g21, r_g22;
    t_sv     n_s1, n_s2, n_t, n_u;
    logic    n_ovf2;
    t_word   r_s1, r_s2, r_t, r_u, r_g11b, r_g22b;
    logic    r_ovf2;
    t_sv     n_e11, n_e22, n_c;
    t_strain r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p11 <= f_smul(i_g11, i_g11);
            r_p21 <= f_smul(i_g21, i_g21);
            r_p12 <= f_smul(i_g12, i_g12);
            r_p22 <= f_smul(i_g22, i_g22);
            r_pa  <= f_smul(i_g11, i_g12);
            r_pb  <= f_smul(i_g21, i_g22);
            r_g11 <= i_g11;
            r_g12 <= i_g12;
            r_g21 <= i_g21;
            r_g22 <= i_g22;
        end
    end

    always_comb begin
        n_s1   = f_sadd(r_p11.val, r_p21.val);
        n_s2   = f_sadd(r_p12.val, r_p22.val);
        n_t    = f_sadd(r_g12, r_g21);
        n_u    = f_sadd(r_pa.val, r_pb.val);
        n_ovf2 = r_p11.ovf | r_p21.ovf | r_p12.ovf | r_p22.ovf | r_pa.ovf | r_pb.ovf
               | n_s1.ovf | n_s2.ovf | n_t.ovf | n_u.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= n_s1.val;
            r_s2   <= n_s2.val;
            r_t    <= n_t.val;
            r_u    <= n_u.val;
            r_g11b <= r_g11;
            r_g22b <= r_g22;
            r_ovf2 <= n_ovf2;
        end
    end

    always_comb begin
        n_e11 = f_sadd(r_g11b, f_asr1(r_s1));
        n_e22 = f_sadd(r_g22b, f_asr1(r_s2));
        n_c   = f_sadd(r_t, r_u);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.e11 <= n_e11.val;
            r_out.e22 <= n_e22.val;
            r_out.e12 <= f_asr1(n_c.val);
            r_out.ovf <= r_ovf2 | n_e11.ovf | n_e22.ovf | n_c.ovf;
        end
    end

    assign o_valid  = r_v3;
    assign o_strain = r_out;

endmodule

### src/ses2d_quad.sv
// Quadratic exponent and its strain derivative, five stages.
`timescale 1ns / 1ps

module ses2d_quad (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ses2d_pkg::t_strain i_strain,
    input  ses2d_pkg::t_coef   i_coef,
    output logic               o_valid,
    output ses2d_pkg::t_quad   o_quad
);
    import ses2d_pkg::*;

    logic [4:0] r_v;

    // stage 1: strain products and coefficient-strain products
    t_sv   n_q [6];
    t_sv   n_m [9];
    logic  n_o1;
    t_word r_q [6];
    t_word r_m [9];
    logic  r_o1;

    // stage 2
    t_sv   n_t [6];
    t_sv   n_da, n_db, n_dc;
    logic  n_o2;
    t_word r_t [6];
    t_word r_da, r_db, r_dc, r_m2, r_m5, r_m8;
    logic  r_o2;

    // stage 3
    t_sv   n_l1, n_x3, n_x5, n_x6, n_d1, n_d2, n_d3;
    t_word r_l1, r_x3, r_x5, r_x6, r_t3, r_d1, r_d2, r_d3;
    logic  r_o3;

    // stage 4
    t_sv   n_l2a, n_l2, n_dd1, n_dd2, n_dd3;
    t_word r_l2, r_x5b, r_x6b;
    logic  r_o4;

    // stage 5
    t_sv   n_l3, n_lam;
    t_quad r_out;
    t_word r_dd1, r_dd2, r_dd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        n_q[0] = f_smul(i_strain.e11, i_strain.e11);
        n_q[1] = f_smul(i_strain.e22, i_strain.e22);
        n_q[2] = f_smul(i_strain.e11, i_strain.e22);
        n_q[3] = f_smul(i_strain.e12, i_strain.e12);
        n_q[4] = f_smul(i_strain.e12, i_strain.e11);
        n_q[5] = f_smul(i_strain.e12, i_strain.e22);
        n_m[0] = f_smul(i_coef.c11,   i_strain.e11);
        n_m[1] = f_smul(i_coef.c1122, i_strain.e22);
        n_m[2] = f_smul(i_coef.c1211, i_strain.e12);
        n_m[3] = f_smul(i_coef.c12,   i_strain.e12);
        n_m[4] = f_smul(i_coef.c1211, i_strain.e11);
        n_m[5] = f_smul(i_coef.c1222, i_strain.e22);
        n_m[6] = f_smul(i_coef.c22,   i_strain.e22);
        n_m[7] = f_smul(i_coef.c1122, i_strain.e11);
        n_m[8] = f_smul(i_coef.c1222, i_strain.e12);
        n_o1 = i_strain.ovf;
        for (int i = 0; i < 6; i++) n_o1 = n_o1 | n_q[i].ovf;
        for (int i = 0; i < 9; i++) n_o1 = n_o1 | n_m[i].ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) r_q[i] <= n_q[i].val;
            for (int i = 0; i < 9; i++) r_m[i] <= n_m[i].val;
            r_o1 <= n_o1;
        end
    end

    always_comb begin
        n_t[0] = f_smul(i_coef.c11,   r_q[0]);
        n_t[1] = f_smul(i_coef.c22,   r_q[1]);
        n_t[2] = f_smul(i_coef.c1122, r_q[2]);
        n_t[3] = f_smul(i_coef.c12,   r_q[3]);
        n_t[4] = f_smul(i_coef.c1211, r_q[4]);
        n_t[5] = f_smul(i_coef.c1222, r_q[5]);
        n_da = f_sadd(r_m[0], r_m[1]);
        n_db = f_sadd(r_m[3], r_m[4]);
        n_dc = f_sadd(r_m[6], r_m[7]);
        n_o2 = r_o1 | n_da.ovf | n_db.ovf | n_dc.ovf;
        for (int i = 0; i < 6; i++) n_o2 = n_o2 | n_t[i].ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 6; i++) r_t[i] <= n_t[i].val;
            r_da <= n_da.val;
            r_db <= n_db.val;
            r_dc <= n_dc.val;
            r_m2 <= r_m[2];
            r_m5 <= r_m[5];
            r_m8 <= r_m[8];
            r_o2 <= n_o2;
        end
    end

    always_comb begin
        n_l1 = f_sadd(r_t[0], r_t[1]);
        n_x3 = f_sadd(r_t[2], r_t[2]);
        n_x5 = f_sadd(r_t[4], r_t[4]);
        n_x6 = f_sadd(r_t[5], r_t[5]);
        n_d1 = f_sadd(r_da, r_m2);
        n_d2 = f_sadd(r_db, r_m5);
        n_d3 = f_sadd(r_dc, r_m8);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l1 <= n_l1.val;
            r_x3 <= n_x3.val;
            r_x5 <= n_x5.val;
            r_x6 <= n_x6.val;
            r_t3 <= r_t[3];
            r_d1 <= n_d1.val;
            r_d2 <= n_d2.val;
            r_d3 <= n_d3.val;
            r_o3 <= r_o2 | n_l1.ovf | n_x3.ovf | n_x5.ovf | n_x6.ovf
                  | n_d1.ovf | n_d2.ovf | n_d3.ovf;
        end
    end

    // exponent sum is accumulated strictly in order, two terms per stage
    always_comb begin
        n_l2a = f_sadd(r_l1, r_x3);
        n_l2  = f_sadd(n_l2a.val, r_t3);
        n_dd1 = f_sadd(r_d1, r_d1);
        n_dd2 = f_sadd(r_d2, r_d2);
        n_dd3 = f_sadd(r_d3, r_d3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l2  <= n_l2.val;
            r_x5b <= r_x5;
            r_x6b <= r_x6;
            r_dd1 <= n_dd1.val;
            r_dd2 <= n_dd2.val;
            r_dd3 <= n_dd3.val;
            r_o4  <= r_o3 | n_l2a.ovf | n_l2.ovf | n_dd1.ovf | n_dd2.ovf | n_dd3.ovf;
        end
    end

    always_comb begin
        n_l3  = f_sadd(r_l2, r_x5b);
        n_lam = f_sadd(n_l3.val, r_x6b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.lam <= n_lam.val;
            r_out.d11 <= r_dd1;
            r_out.d12 <= r_dd2;
            r_out.d22 <= r_dd3;
            r_out.ovf <= r_o4 | n_l3.ovf | n_lam.ovf;
        end
    end

    assign o_valid = r_v[4];
    assign o_quad  = r_out;

endmodule

### src/ses2d_exp.sv
// Pipelined fixed-point exp: base-2 range reduction and a twelve-term Horner series.
`timescale 1ns / 1ps

module ses2d_exp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  ses2d_pkg::t_quad i_quad,
    output logic             o_valid,
    output ses2d_pkg::t_quad o_quad,
    output ses2d_pkg::t_word o_exp
);
    import ses2d_pkg::*;

    localparam int HSTG = 3 * TERMS;
    localparam int ACC_W = EXP_FRAC + 3;
    localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << EXP_FRAC;

    typedef struct packed {
        t_quad             side;
        logic signed [7:0] n;
        logic [EXP_FRAC-1:0] r;
        logic              big;
        logic              tiny;
    } t_ecar;

    // stage X1: range check and scaling by log2(e)
    logic                   n_neg;
    logic [WORD_W-1:0]      n_mag;
    logic [63:0]            n_prod;
    logic [EXP_FRAC+6:0]    n_ym;
    logic                   r_x1_v;
    logic signed [EXP_FRAC+7:0] r_x1_y;
    logic                   r_x1_big, r_x1_tiny;
    t_quad                  r_x1_side;

    // stage X2: split into integer and fraction, scale fraction by ln2
    logic [63:0]            n_rp;
    logic                   w_cv [0:HSTG];
    t_ecar                  w_cc [0:HSTG];
    logic [ACC_W-1:0]       w_acc [0:TERMS];
    logic                   r_x2_v;
    t_ecar                  r_x2_c;

    // final stage
    logic signed [8:0]      n_s;
    logic [5:0]             n_sh;
    logic [ACC_W:0]         n_rnd;
    logic [ACC_W-1:0]       n_acc;
    t_word                  n_e;
    logic                   n_eovf;
    t_quad                  n_f_side;
    logic                   r_f_v;
    t_quad                  r_f_side;
    t_word                  r_f_e;

    always_comb begin
        n_neg  = i_quad.lam[WORD_W-1];
        n_mag  = n_neg ? WORD_W'(-i_quad.lam) : WORD_W'(i_quad.lam);
        n_prod = 64'(n_mag) * 64'(LOG2E_Q30);
        n_ym   = (EXP_FRAC+7)'((n_prod + (64'd1 << (FRAC_W - 1))) >> FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
            r_f_v  <= 1'b0;
        end else if (i_en) begin
            r_x1_v <= i_valid;
            r_x2_v <= r_x1_v;
            r_f_v  <= w_cv[HSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1_big  <= i_quad.lam > EXP_LIM;
            r_x1_tiny <= i_quad.lam < -EXP_LIM;
            r_x1_y    <= n_neg ? -$signed({1'b0, n_ym}) : $signed({1'b0, n_ym});
            r_x1_side <= i_quad;
        end
    end

    assign n_rp = 64'(r_x1_y[EXP_FRAC-1:0]) * 64'(LN2_Q30) + (64'd1 << (EXP_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2_c.side <= r_x1_side;
            r_x2_c.n    <= r_x1_y[EXP_FRAC+7:EXP_FRAC];
            r_x2_c.r    <= EXP_FRAC'(n_rp >> EXP_FRAC);
            r_x2_c.big  <= r_x1_big;
            r_x2_c.tiny <= r_x1_tiny;
        end
    end

    assign w_cv[0]  = r_x2_v;
    assign w_cc[0]  = r_x2_c;
    assign w_acc[0] = ONE_Q;

    // each term: multiply, divide by k via reciprocal, correct and add one
    for (genvar j = 0; j < TERMS; j++) begin : g_term
        localparam int K = TERMS - j;
        localparam logic [34:0] RECIP = 35'((64'd1 << 34) / K);
        localparam logic [33:0] HALF_K = 34'(K / 2);

        logic [63:0]      n_tp;
        logic [33:0]      n_num;
        logic [71:0]      n_qp;
        logic [39:0]      n_rem;
        logic [33:0]      n_q;
        logic             r_va, r_vb, r_vc;
        t_ecar            r_ca, r_cb, r_cc;
        logic [ACC_W-1:0] r_t;
        logic [33:0]      r_num, r_q0;
        logic [ACC_W-1:0] r_acc;

        assign n_tp  = 64'(w_acc[j]) * 64'(w_cc[3*j].r) + (64'd1 << (EXP_FRAC - 1));
        assign n_num = 34'(r_t) + HALF_K;
        assign n_qp  = 72'(n_num) * 72'(RECIP);
        // estimate is low by at most one
        assign n_rem = 40'(r_num) - 40'(r_q0) * 40'(K);
        assign n_q   = (n_rem >= 40'(K)) ? r_q0 + 34'd1 : r_q0;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va <= 1'b0;
                r_vb <= 1'b0;
                r_vc <= 1'b0;
            end else if (i_en) begin
                r_va <= w_cv[3*j];
                r_vb <= r_va;
                r_vc <= r_vb;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ca  <= w_cc[3*j];
                r_t   <= ACC_W'(n_tp >> EXP_FRAC);
                r_cb  <= r_ca;
                r_num <= n_num;
                r_q0  <= 34'(n_qp >> 34);
                r_cc  <= r_cb;
                r_acc <= ACC_W'(34'(ONE_Q) + n_q);
            end
        end

        assign w_cv[3*j+3] = r_vc;
        assign w_cc[3*j+3] = r_cc;
        assign w_acc[j+1]  = r_acc;

        assign w_cv[3*j+1] = r_va;
        assign w_cc[3*j+1] = r_ca;
        assign w_cv[3*j+2] = r_vb;
        assign w_cc[3*j+2] = r_cb;
    end

    // scale by 2^n; acc is at least one, so any left shift past zero saturates
    always_comb begin
        n_acc  = w_acc[TERMS];
        n_s    = 9'(w_cc[HSTG].n) - 9'sd14;
        n_sh   = 6'(-n_s);
        n_rnd  = (ACC_W+1)'(n_acc) + ((ACC_W+1)'(1) << (n_sh - 6'd1));
        n_e    = '0;
        n_eovf = 1'b0;
        if (w_cc[HSTG].big) begin
            n_e    = WORD_MAX;
            n_eovf = 1'b1;
        end else if (w_cc[HSTG].tiny) begin
            n_e = '0;
        end else if (n_s >= 0) begin
            if (n_s == 9'sd0 && n_acc <= ACC_W'(WORD_MAX)) begin
                n_e = t_word'(n_acc[WORD_W-1:0]);
            end else begin
                n_e    = WORD_MAX;
                n_eovf = 1'b1;
            end
        end else if (n_s < -9'sd32) begin
            n_e = '0;
        end else begin
            n_e = t_word'(WORD_W'(n_rnd >> n_sh));
        end
        n_f_side     = w_cc[HSTG].side;
        n_f_side.ovf = w_cc[HSTG].side.ovf | n_eovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_side <= n_f_side;
            r_f_e    <= n_e;
        end
    end

    assign o_valid = r_f_v;
    assign o_quad  = r_f_side;
    assign o_exp   = r_f_e;

endmodule

### src/exp_strain_energy_stress_2d.sv
// Top level: config registers, strain, exponent, exp and stress output stages.
//
// channel  direction  handshake                  payload
// in       to block   i_in_valid / o_in_stall    i_grad_u_11, _12, _21, _22
// out      from block o_out_valid / i_out_stall  o_stress_11/_12/_22, o_energy_exponent, o_overflow
// cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; the strain, exponent, exp and stress stages follow in that order.
// The exp unit dominates: three stages for each of the twelve series terms.
// Reset clears all valid bits and the config registers to zero; cfg is always ready.
// A stall on a valid output freezes the whole pipeline at once, and o_in_stall rises in the same cycle.
`timescale 1ns / 1ps

module exp_strain_energy_stress_2d (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ses2d_pkg::t_word                  i_grad_u_11,
    input  ses2d_pkg::t_word                  i_grad_u_12,
    input  ses2d_pkg::t_word                  i_grad_u_21,
    input  ses2d_pkg::t_word                  i_grad_u_22,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ses2d_pkg::t_word                  o_stress_11,
    output ses2d_pkg::t_word                  o_stress_12,
    output ses2d_pkg::t_word                  o_stress_22,
    output ses2d_pkg::t_word                  o_energy_exponent,
    output logic                              o_overflow,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ses2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  ses2d_pkg::t_word                  i_cfg_data
);
    import ses2d_pkg::*;

    logic    w_en;
    t_coef   r_cfg;
    logic    w_str_v;
    t_strain w_str;
    logic    w_quad_v;
    t_quad   w_quad;
    logic    w_exp_v;
    t_quad   w_exp_side;
    t_word   w_exp;

    t_sv     n_ae;
    t_quad   n_t1_side;
    logic    r_t1_v;
    t_word   r_t1_ae;
    t_quad   r_t1_side;

    t_sv     n_p11, n_p12, n_p22;
    logic    r_t2_v;
    t_word   r_t2_p11, r_t2_p12, r_t2_p22, r_t2_lam;
    logic    r_t2_ovf;

    logic    r_out_v;
    t_word   r_s11, r_s12, r_s22, r_lam;
    logic    r_ovf;

    assign w_en        = ~(r_out_v & i_out_stall);
    assign o_in_stall  = ~w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SCALE:   r_cfg.a     <= i_cfg_data;
                REG_E11_SQ:  r_cfg.c11   <= i_cfg_data;
                REG_E22_SQ:  r_cfg.c22   <= i_cfg_data;
                REG_E11_E22: r_cfg.c1122 <= i_cfg_data;
                REG_E12_SQ:  r_cfg.c12   <= i_cfg_data;
                REG_E12_E11: r_cfg.c1211 <= i_cfg_data;
                REG_E12_E22: r_cfg.c1222 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ses2d_strain u_strain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_g11    (i_grad_u_11),
        .i_g12    (i_grad_u_12),
        .i_g21    (i_grad_u_21),
        .i_g22    (i_grad_u_22),
        .o_valid  (w_str_v),
        .o_strain (w_str)
    );

    ses2d_quad u_quad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_str_v),
        .i_strain (w_str),
        .i_coef   (r_cfg),
        .o_valid  (w_quad_v),
        .o_quad   (w_quad)
    );

    ses2d_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_quad_v),
        .i_quad  (w_quad),
        .o_valid (w_exp_v),
        .o_quad  (w_exp_side),
        .o_exp   (w_exp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v  <= 1'b0;
            r_t2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_t1_v  <= w_exp_v;
            r_t2_v  <= r_t1_v;
            r_out_v <= r_t2_v;
        end
    end

    always_comb begin
        n_ae          = f_smul(r_cfg.a, w_exp);
        n_t1_side     = w_exp_side;
        n_t1_side.ovf = w_exp_side.ovf | n_ae.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_ae   <= n_ae.val;
            r_t1_side <= n_t1_side;
        end
    end

    always_comb begin
        n_p11 = f_smul(r_t1_ae, r_t1_side.d11);
        n_p12 = f_smul(r_t1_ae, r_t1_side.d12);
        n_p22 = f_smul(r_t1_ae, r_t1_side.d22);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t2_p11 <= n_p11.val;
            r_t2_p12 <= n_p12.val;
            r_t2_p22 <= n_p22.val;
            r_t2_lam <= r_t1_side.lam;
            r_t2_ovf <= r_t1_side.ovf | n_p11.ovf | n_p12.ovf | n_p22.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s11 <= f_asr1(r_t2_p11);
            r_s12 <= f_asr1(r_t2_p12);
            r_s22 <= f_asr1(r_t2_p22);
            r_lam <= r_t2_lam;
            r_ovf <= r_t2_ovf;
        end
    end

    assign o_out_valid       = r_out_v;
    assign o_stress_11       = r_s11;
    assign o_stress_12       = r_s12;
    assign o_stress_22       = r_s22;
    assign o_energy_exponent = r_lam;
    assign o_overflow        = r_ovf;

    // exp never yields a negative value
    a_exp_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exp_v |-> !w_exp[WORD_W-1])
        else $error("exp result negative");

    // exponent above the exp range must be flagged
    a_big_exp_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_energy_exponent > EXP_LIM) |-> o_overflow)
        else $error("large exponent without overflow");

    // zero stiffness scale gives zero stress
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.a == '0)
        |-> (o_stress_11 == '0 && o_stress_12 == '0 && o_stress_22 == '0))
        else $error("nonzero stress with zero scale");

endmodule
